// File: rtl/core/assert_macros.svh
// assertion helpers shared by the deque rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every clock edge out of reset
`define RDQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define RDQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// consequent holds in the cycle after the antecedent
`define RDQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RDQ_ASSERT(label, prop, msg)
`define RDQ_ASSERT_IMPL(label, ante, cons, msg)
`define RDQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/core/rdq_pkg.sv
`timescale 1ns / 1ps

package rdq_pkg;

	// storage geometry
	localparam int CAPACITY  = 256;
	localparam int DATA_BITS = 32;
	localparam int IDX_BITS  = $clog2(CAPACITY);
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);
	localparam int SUM_BITS  = CNT_BITS + 1;

	// port field widths
	localparam int OP_BITS       = 3;
	localparam int POS_BITS      = 8;
	localparam int DATA_IN_BITS  = 32;
	localparam int DATA_OUT_BITS = 32;
	localparam int STATUS_BITS   = 2;
	localparam int OCC_BITS      = 9;
	localparam int CMP_BITS      = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

	// operation codes
	typedef enum logic [OP_BITS-1:0] {
		OP_GET        = 3'd0,
		OP_PUT        = 3'd1,
		OP_PUSH_FRONT = 3'd2,
		OP_PUSH_BACK  = 3'd3,
		OP_POP_FRONT  = 3'd4,
		OP_POP_BACK   = 3'd5
	} op_t;

	// result status codes
	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// source of the result data
	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_DIN,
		SEL_MEM
	} sel_t;

	// decision for one operation, from the pointer unit to the datapath
	typedef struct packed {
		status_t               status;
		sel_t                  sel;
		logic                  we;
		logic [IDX_BITS-1:0]   addr;
		logic [CNT_BITS-1:0]   fill_next;
	} dec_t;

endpackage

// File: rtl/core/rdq_in_if.sv
`timescale 1ns / 1ps

interface rdq_in_if;
	import rdq_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_BITS-1:0]      operation;
	logic [POS_BITS-1:0]     position;
	logic [DATA_IN_BITS-1:0] data_in;

	modport source (output valid, output operation, output position, output data_in,
		input ready);
	modport sink (input valid, input operation, input position, input data_in,
		output ready);
endinterface

// File: rtl/core/rdq_out_if.sv
`timescale 1ns / 1ps

interface rdq_out_if;
	import rdq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [DATA_OUT_BITS-1:0] data_out;
	logic [STATUS_BITS-1:0]   status;
	logic [OCC_BITS-1:0]      occupancy;

	modport source (output valid, output data_out, output status, output occupancy,
		input ready);
	modport sink (input valid, input data_out, input status, input occupancy,
		output ready);
endinterface

// File: rtl/core/ring_deque_indexed_unit.sv
// a request is held in the stage one registers, then in the output register, before its result is offered
// throughput: one operation per cycle while the result side is ready; the store is read at transfer through one port
// and written back from stage one through another, with a bypass for a read of the entry in flight
// reset: arst_n clears the front pointer, the count and all valid flags;
// the store itself is not cleared and needs no sweep
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ring_deque_indexed_unit (
	input  logic       clk,
	input  logic       arst_n,
	rdq_in_if.sink     req,
	rdq_out_if.source  rsp
);
	import rdq_pkg::*;

	logic [DATA_BITS-1:0] mem [CAPACITY];

	dec_t                     dec;
	logic                     acc;
	logic                     s1_go;
	logic                     mem_we;
	logic                     fwd_hit;
	logic                     s1_v_q;
	status_t                  s1_status_q;
	sel_t                     s1_sel_q;
	logic                     s1_we_q;
	logic [IDX_BITS-1:0]      s1_addr_q;
	logic [DATA_BITS-1:0]     s1_din_q;
	logic [CNT_BITS-1:0]      s1_occ_q;
	logic                     fwd_s1;
	logic [DATA_BITS-1:0]     fwd_data_s1;
	logic [DATA_BITS-1:0]     rd_data_s1;
	logic [DATA_BITS-1:0]     mem_data;
	logic [DATA_BITS-1:0]     s1_data;
	logic                     out_v_q;
	logic [DATA_OUT_BITS-1:0] out_data_q;
	status_t                  out_status_q;
	logic [OCC_BITS-1:0]      out_occ_q;

	// handshake
	assign s1_go     = !out_v_q || rsp.ready;
	assign req.ready = !s1_v_q || s1_go;
	assign acc       = req.valid && req.ready;
	assign mem_we    = s1_v_q && s1_go && s1_we_q;
	assign fwd_hit   = mem_we && (s1_addr_q == dec.addr);

	rdq_ptr u_ptr (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.operation (req.operation),
		.position  (req.position),
		.dec       (dec)
	);

	// store: write back from stage one, read at transfer
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[s1_addr_q] <= s1_din_q;
		end
		if (acc) begin
			rd_data_s1 <= mem[dec.addr];
		end
	end

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			fwd_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				s1_v_q <= 1'b1;
				fwd_s1 <= fwd_hit;
			end else if (s1_go) begin
				s1_v_q <= 1'b0;
			end
			if (s1_go) begin
				out_v_q <= s1_v_q;
			end
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (acc) begin
			s1_status_q <= dec.status;
			s1_sel_q    <= dec.sel;
			s1_we_q     <= dec.we;
			s1_addr_q   <= dec.addr;
			s1_din_q    <= DATA_BITS'(req.data_in);
			s1_occ_q    <= dec.fill_next;
			fwd_data_s1 <= s1_din_q;
		end
	end

	// result data select with bypass of the entry written at transfer
	assign mem_data = fwd_s1 ? fwd_data_s1 : rd_data_s1;

	always_comb begin
		unique case (s1_sel_q)
			SEL_DIN: s1_data = s1_din_q;
			SEL_MEM: s1_data = mem_data;
			default: s1_data = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (s1_go && s1_v_q) begin
			out_data_q   <= DATA_OUT_BITS'(s1_data);
			out_status_q <= s1_status_q;
			out_occ_q    <= OCC_BITS'(s1_occ_q);
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.data_out  = out_data_q;
	assign rsp.status    = out_status_q;
	assign rsp.occupancy = out_occ_q;

	`RDQ_ASSERT_IMPL(a_stall_blocks, s1_v_q && !s1_go, !req.ready, "input taken while stage one held")
	`RDQ_ASSERT_NEXT(a_fwd_source, acc && fwd_hit, fwd_s1, "bypass flag not captured")
	`RDQ_ASSERT_NEXT(a_transfer_fills, acc, s1_v_q, "transfer did not load stage one")

endmodule

// File: rtl/core/rdq_ptr.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rdq_ptr (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   acc,
	input  logic [rdq_pkg::OP_BITS-1:0]  operation,
	input  logic [rdq_pkg::POS_BITS-1:0] position,
	output rdq_pkg::dec_t          dec
);
	import rdq_pkg::*;

	logic [IDX_BITS-1:0] front_q;
	logic [CNT_BITS-1:0] fill_q;
	logic [IDX_BITS-1:0] front_nxt;
	logic [CNT_BITS-1:0] offset;
	logic [IDX_BITS-1:0] off_addr;
	logic [IDX_BITS-1:0] pf_addr;
	logic [IDX_BITS-1:0] inc_front;
	logic                is_full;
	logic                is_empty;
	logic                in_range;

	// reduce a sum of an index and an offset below the capacity
	function automatic logic [IDX_BITS-1:0] wrap_idx(input logic [SUM_BITS-1:0] s);
		logic [SUM_BITS-1:0] r;
		r = (s >= SUM_BITS'(CAPACITY)) ? (s - SUM_BITS'(CAPACITY)) : s;
		return r[IDX_BITS-1:0];
	endfunction

	// shared address arithmetic
	assign is_full   = (fill_q == CNT_BITS'(CAPACITY));
	assign is_empty  = (fill_q == '0);
	assign in_range  = (CMP_BITS'(position) < CMP_BITS'(fill_q));
	assign off_addr  = wrap_idx(SUM_BITS'(front_q) + SUM_BITS'(offset));
	assign inc_front = wrap_idx(SUM_BITS'(front_q) + SUM_BITS'(1));
	assign pf_addr   = (front_q == '0) ? IDX_BITS'(CAPACITY - 1) : front_q - IDX_BITS'(1);

	// logical offset from the front for the addressed element
	always_comb begin
		unique case (operation)
			OP_GET, OP_PUT: offset = CNT_BITS'(position);
			OP_PUSH_BACK:   offset = fill_q;
			OP_POP_BACK:    offset = fill_q - CNT_BITS'(1);
			default:        offset = '0;
		endcase
	end

	// operation decode
	always_comb begin
		dec.status    = ST_OK;
		dec.sel       = SEL_ZERO;
		dec.we        = 1'b0;
		dec.addr      = off_addr;
		dec.fill_next = fill_q;
		front_nxt     = front_q;
		unique case (operation)
			OP_GET, OP_PUT: begin
				if (!in_range) begin
					dec.status = ST_RANGE;
				end else begin
					dec.sel = SEL_MEM;
					dec.we  = (operation == OP_PUT);
				end
			end
			OP_PUSH_FRONT: begin
				if (is_full) begin
					dec.status = ST_FULL;
				end else begin
					dec.sel       = SEL_DIN;
					dec.we        = 1'b1;
					dec.addr      = pf_addr;
					dec.fill_next = fill_q + CNT_BITS'(1);
					front_nxt     = pf_addr;
				end
			end
			OP_PUSH_BACK: begin
				if (is_full) begin
					dec.status = ST_FULL;
				end else begin
					dec.sel       = SEL_DIN;
					dec.we        = 1'b1;
					dec.fill_next = fill_q + CNT_BITS'(1);
				end
			end
			OP_POP_FRONT: begin
				if (is_empty) begin
					dec.status = ST_EMPTY;
				end else begin
					dec.sel       = SEL_MEM;
					dec.fill_next = fill_q - CNT_BITS'(1);
					front_nxt     = inc_front;
				end
			end
			OP_POP_BACK: begin
				if (is_empty) begin
					dec.status = ST_EMPTY;
				end else begin
					dec.sel       = SEL_MEM;
					dec.fill_next = fill_q - CNT_BITS'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// front pointer and element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			fill_q  <= '0;
		end else if (acc) begin
			front_q <= front_nxt;
			fill_q  <= dec.fill_next;
		end
	end

	`RDQ_ASSERT(a_fill_bound, fill_q <= CNT_BITS'(CAPACITY), "count above capacity")
	`RDQ_ASSERT_NEXT(a_err_hold, acc && (dec.status != ST_OK), $stable(fill_q) && $stable(front_q), "flagged operation changed state")
	`RDQ_ASSERT_NEXT(a_push_grow, acc && (dec.status == ST_OK) && ((operation == OP_PUSH_FRONT) || (operation == OP_PUSH_BACK)), fill_q == $past(fill_q) + CNT_BITS'(1), "push did not grow count")

endmodule

// File: sim/tb_ring_deque_indexed_unit.sv
`timescale 1ns / 1ps

module tb_ring_deque_indexed_unit;
	import rdq_pkg::*;

	// codes outside the defined set, the block must leave state alone
	localparam logic [OP_BITS-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_BITS-1:0] OP_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [DATA_OUT_BITS-1:0] data;
		status_t                  status;
		logic [OCC_BITS-1:0]      occ;
	} deque_result_t;

	logic clk = 1'b0;
	logic arst_n;

	rdq_in_if  req_if ();
	rdq_out_if rsp_if ();

	ring_deque_indexed_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// shadow copy of the deque
	logic [DATA_BITS-1:0] ring_store [CAPACITY];
	logic [IDX_BITS-1:0]  ring_head;
	logic [CNT_BITS-1:0]  ring_fill;

	deque_result_t pending_results [$];
	int            mismatch_count;
	bit            no_gaps;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// apply one operation to the shadow deque and return its result
	function automatic deque_result_t deque_apply(logic [OP_BITS-1:0] op,
		logic [POS_BITS-1:0] pos, logic [DATA_IN_BITS-1:0] din);
		deque_result_t        r;
		logic [IDX_BITS-1:0]  slot;
		r.data   = '0;
		r.status = ST_OK;
		case (op)
			OP_GET, OP_PUT: begin
				if ({1'b0, pos} >= ring_fill) begin
					r.status = ST_RANGE;
				end else begin
					slot = ring_head + pos;
					r.data = ring_store[slot];
					if (op == OP_PUT)
						ring_store[slot] = din;
				end
			end
			OP_PUSH_FRONT: begin
				if (ring_fill == CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					ring_head = ring_head - 1'b1;
					ring_store[ring_head] = din;
					ring_fill = ring_fill + 1'b1;
					r.data = din;
				end
			end
			OP_PUSH_BACK: begin
				if (ring_fill == CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					slot = ring_head + ring_fill[IDX_BITS-1:0];
					ring_store[slot] = din;
					ring_fill = ring_fill + 1'b1;
					r.data = din;
				end
			end
			OP_POP_FRONT: begin
				if (ring_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.data = ring_store[ring_head];
					ring_head = ring_head + 1'b1;
					ring_fill = ring_fill - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (ring_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					ring_fill = ring_fill - 1'b1;
					slot = ring_head + ring_fill[IDX_BITS-1:0];
					r.data = ring_store[slot];
				end
			end
			default: ;
		endcase
		r.occ = ring_fill;
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		if (no_gaps)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic void log_failure(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch: %s", msg);
	endfunction

	// one request transfer, expectation recorded at the accepting edge
	task automatic send_op(input logic [OP_BITS-1:0] op, input logic [POS_BITS-1:0] pos,
		input logic [DATA_IN_BITS-1:0] din);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.operation <= op;
		req_if.position  <= pos;
		req_if.data_in   <= din;
		do @(posedge clk); while (!req_if.ready);
		pending_results.push_back(deque_apply(op, pos, din));
	endtask

	// stop sending until every outstanding result is back
	task automatic hold_until_empty();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// empty-queue errors, spare codes, data extremes, small wrap at slot zero
	task automatic test_directed();
		send_op(OP_POP_FRONT, 8'h00, 32'h0000_0000);
		send_op(OP_POP_BACK, 8'hff, 32'hffff_ffff);
		send_op(OP_GET, 8'h00, 32'h0000_0000);
		send_op(OP_PUT, 8'hff, 32'hffff_ffff);
		send_op(OP_SPARE_LO, 8'hff, 32'hffff_ffff);
		send_op(OP_SPARE_HI, 8'h00, 32'h0000_0000);
		send_op(OP_PUSH_BACK, 8'h00, 32'h0000_0000);
		send_op(OP_PUSH_BACK, 8'hff, 32'hffff_ffff);
		send_op(OP_PUSH_FRONT, 8'h55, 32'h8000_0001);
		send_op(OP_PUSH_FRONT, 8'haa, 32'h7fff_fffe);
		send_op(OP_GET, 8'h00, 32'h0000_0000);
		send_op(OP_GET, 8'h03, 32'h0000_0000);
		send_op(OP_GET, 8'h04, 32'h0000_0000);
		send_op(OP_PUT, 8'h01, 32'h5a5a_5a5a);
		send_op(OP_PUT, 8'h02, 32'h0000_0000);
		send_op(OP_PUT, 8'h04, 32'ha5a5_a5a5);
		send_op(OP_GET, 8'h01, 32'h0000_0000);
		send_op(OP_SPARE_HI, 8'h01, 32'h1234_5678);
		send_op(OP_POP_FRONT, 8'h00, 32'h0000_0000);
		send_op(OP_POP_BACK, 8'h00, 32'h0000_0000);
		send_op(OP_POP_BACK, 8'h00, 32'h0000_0000);
		send_op(OP_POP_FRONT, 8'h00, 32'h0000_0000);
		send_op(OP_POP_FRONT, 8'h00, 32'h0000_0000);
		hold_until_empty();
	endtask

	// fill to capacity from both ends, refuse further pushes, index the far end, drain
	task automatic test_fill_and_drain();
		for (int i = 0; i < CAPACITY; i++)
			send_op((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK,
				POS_BITS'($urandom_range(0, 255)), $urandom);
		send_op(OP_PUSH_FRONT, 8'h00, $urandom);
		send_op(OP_PUSH_BACK, 8'hff, $urandom);
		send_op(OP_GET, 8'hff, 32'h0000_0000);
		send_op(OP_GET, 8'h00, 32'h0000_0000);
		send_op(OP_PUT, 8'hff, $urandom);
		send_op(OP_PUT, 8'h80, $urandom);
		send_op(OP_SPARE_LO, 8'h80, $urandom);
		send_op(OP_GET, 8'hff, 32'h0000_0000);
		for (int i = 0; i < CAPACITY; i++)
			send_op((i % 3) ? OP_POP_BACK : OP_POP_FRONT,
				POS_BITS'($urandom_range(0, 255)), $urandom);
		send_op(OP_POP_BACK, 8'h00, 32'h0000_0000);
		hold_until_empty();
	endtask

	// random traffic, occupancy drifting up and down in phases
	task automatic test_random_mix(input int n_items);
		int                  grow_pct;
		int                  roll;
		logic [OP_BITS-1:0]  op;
		logic [POS_BITS-1:0] pos;
		grow_pct = 50;
		for (int i = 0; i < n_items; i++) begin
			if (i % 150 == 0) begin
				case ($urandom_range(0, 2))
					0: grow_pct = 75;
					1: grow_pct = 25;
					default: grow_pct = 50;
				endcase
				no_gaps = ($urandom_range(0, 4) == 0);
			end
			if (i == n_items / 2)
				hold_until_empty();
			roll = $urandom_range(0, 99);
			if (roll < 3)
				op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
			else if (roll < 30)
				op = $urandom_range(0, 1) ? OP_PUT : OP_GET;
			else if ($urandom_range(0, 99) < grow_pct)
				op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
			else
				op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
			if (ring_fill != 0 && $urandom_range(0, 9) < 8)
				pos = POS_BITS'($urandom_range(0, ring_fill - 1));
			else
				pos = POS_BITS'($urandom_range(0, 255));
			send_op(op, pos, $urandom);
		end
		no_gaps = 1'b0;
		hold_until_empty();
	endtask

	// result side back-pressure
	initial begin : sink_pacing
		int run_len;
		int stall_len;
		rsp_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			run_len = $urandom_range(1, 24);
			rsp_if.ready <= 1'b1;
			repeat (run_len) @(posedge clk);
			stall_len = pick_gap();
			if (stall_len > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// compare each result transfer against the oldest expectation
	always @(posedge clk) begin : result_check
		deque_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				log_failure($sformatf("unexpected result data=%h status=%0d occ=%0d",
					rsp_if.data_out, rsp_if.status, rsp_if.occupancy));
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.data_out !== want.data || rsp_if.status !== want.status ||
					rsp_if.occupancy !== want.occ)
					log_failure($sformatf(
						"exp data=%h status=%0d occ=%0d, got data=%h status=%0d occ=%0d",
						want.data, want.status, want.occ,
						rsp_if.data_out, rsp_if.status, rsp_if.occupancy));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		mismatch_count = 0;
		no_gaps        = 1'b0;
		ring_head      = '0;
		ring_fill      = '0;
		for (int i = 0; i < CAPACITY; i++)
			ring_store[i] = '0;
		arst_n           <= 1'b0;
		req_if.valid     <= 1'b0;
		req_if.operation <= '0;
		req_if.position  <= '0;
		req_if.data_in   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_drain();
		test_random_mix(400);

		// catch any stray result after the last expected one
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			log_failure($sformatf("%0d results never arrived", pending_results.size()));
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
